[sv/cc20_pkg.sv]
package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef enum logic [2:0] {
    REG_KEY_0_7     = 3'd0,
    REG_KEY_8_15    = 3'd1,
    REG_KEY_16_23   = 3'd2,
    REG_KEY_24_31   = 3'd3,
    REG_NONCE_0_7   = 3'd4,
    REG_NONCE_8_11  = 3'd5
  } cc20_reg_t;

  typedef logic [15:0][31:0] cc20_block_t;

  typedef struct packed {
    logic [95:0]  nonce;
    logic [255:0] key;
  } cc20_cfg_t;

  // one queued byte, already tagged by the front end
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic       build;
    logic       first;
  } cc20_item_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic cc20_block_t init_block(input cc20_cfg_t cfg, input logic [31:0] ctr);
    cc20_block_t b;
    b[0] = SIGMA0;
    b[1] = SIGMA1;
    b[2] = SIGMA2;
    b[3] = SIGMA3;
    for (int k = 0; k < 8; k++) begin
      b[4 + k] = cfg.key[32 * k +: 32];
    end
    b[12] = ctr;
    b[13] = cfg.nonce[31:0];
    b[14] = cfg.nonce[63:32];
    b[15] = cfg.nonce[95:64];
    return b;
  endfunction

endpackage

[sv/cc20_regs.sv]
module cc20_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cc20_pkg::ADDR_W-1:0]   paddr,
  input  logic [cc20_pkg::DATA_W-1:0]   pwdata,
  output logic [cc20_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cc20_pkg::cc20_cfg_t           cfg
);

  logic [cc20_pkg::DATA_W-1:0] regs_r [6];
  logic [2:0]                  idx;
  logic                        wr_en;

  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en) begin
      case (idx) inside
        [cc20_pkg::REG_KEY_0_7:cc20_pkg::REG_NONCE_0_7]: regs_r[idx] <= pwdata;
        cc20_pkg::REG_NONCE_8_11: regs_r[idx] <= {32'd0, pwdata[31:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    if (idx <= cc20_pkg::REG_NONCE_8_11) begin
      prdata = regs_r[idx];
    end else begin
      prdata = '0;
    end
  end

  assign cfg.key   = {regs_r[cc20_pkg::REG_KEY_24_31], regs_r[cc20_pkg::REG_KEY_16_23],
                      regs_r[cc20_pkg::REG_KEY_8_15], regs_r[cc20_pkg::REG_KEY_0_7]};
  assign cfg.nonce = {regs_r[cc20_pkg::REG_NONCE_8_11][31:0],
                      regs_r[cc20_pkg::REG_NONCE_0_7]};

endmodule

[sv/cc20_front.sv]
module cc20_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_first,
  output logic                  q_valid,
  output cc20_pkg::cc20_item_t  q_item,
  input  logic                  q_pop
);

  localparam int DEPTH = cc20_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cc20_pkg::cc20_item_t queue_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;
  logic [5:0]           pos_r;
  logic [5:0]           pos_eff;
  logic                 push;
  cc20_pkg::cc20_item_t entry;

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = queue_r[rd_ptr_r];

  // byte position tracked here so the back end knows up front which bytes start a block
  assign pos_eff     = in_first ? 6'd0 : pos_r;
  assign entry.data  = in_data_byte;
  assign entry.pos   = pos_eff;
  assign entry.build = (pos_eff == 6'd0);
  assign entry.first = in_first;

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      pos_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
        pos_r    <= pos_eff + 6'd1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

[sv/cc20_core.sv]
module cc20_core #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cc20_pkg::cc20_cfg_t   cfg,
  input  logic                  q_valid,
  input  cc20_pkg::cc20_item_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_cipher_byte
);

  localparam int RND_W = $clog2(DOUBLE_ROUNDS + 1);

  typedef enum logic [1:0] {
    ST_READY,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  state_t                state_r;
  cc20_pkg::cc20_block_t w_r;
  cc20_pkg::cc20_block_t w_nxt;
  cc20_pkg::cc20_block_t ks_r;
  cc20_pkg::cc20_block_t init_cur;
  logic [31:0]           counter_r;
  logic [31:0]           cnt_eff;
  logic [2:0]            sub_r;
  logic [RND_W-1:0]      rnd_r;
  logic [7:0]            hold_data_r;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_free;
  logic                  out_load;
  logic [31:0]           ks_word;
  logic [7:0]            ks_byte;
  logic                  diag;
  logic [3:0]            ia, ib, ic, id;
  logic [31:0]           a, b, c, d;
  logic [31:0]           na, nb, nc, nd;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_READY) && q_valid && (q_item.build || out_free);
  assign out_load = q_pop ? !q_item.build : ((state_r == ST_EMIT) && out_free);
  assign cnt_eff  = q_item.first ? 32'd0 : counter_r;
  assign init_cur = cc20_pkg::init_block(cfg, counter_r);

  assign ks_word = ks_r[q_item.pos[5:2]];
  assign ks_byte = ks_word[{q_item.pos[1:0], 3'b000} +: 8];

  // sub_r[2] picks column or diagonal half; sub_r[1:0] is the quarter-round step.
  // One add per step, four lanes side by side.
  assign diag = sub_r[2];

  always_comb begin
    w_nxt = w_r;
    for (int j = 0; j < 4; j++) begin
      ia = 4'(j);
      ib = diag ? 4'(4 + ((j + 1) & 3)) : 4'(4 + j);
      ic = diag ? 4'(8 + ((j + 2) & 3)) : 4'(8 + j);
      id = diag ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
      a  = w_r[ia];
      b  = w_r[ib];
      c  = w_r[ic];
      d  = w_r[id];
      na = a;
      nb = b;
      nc = c;
      nd = d;
      case (sub_r[1:0])
        2'd0: begin
          na = a + b;
          nd = cc20_pkg::rotl32(d ^ na, cc20_pkg::ROT_A);
        end
        2'd1: begin
          nc = c + d;
          nb = cc20_pkg::rotl32(b ^ nc, cc20_pkg::ROT_B);
        end
        2'd2: begin
          na = a + b;
          nd = cc20_pkg::rotl32(d ^ na, cc20_pkg::ROT_C);
        end
        default: begin
          nc = c + d;
          nb = cc20_pkg::rotl32(b ^ nc, cc20_pkg::ROT_D);
        end
      endcase
      w_nxt[ia] = na;
      w_nxt[ib] = nb;
      w_nxt[ic] = nc;
      w_nxt[id] = nd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      counter_r   <= '0;
      sub_r       <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_READY: begin
          if (q_pop) begin
            if (q_item.build) begin
              hold_data_r <= q_item.data;
              counter_r   <= cnt_eff;
              w_r         <= cc20_pkg::init_block(cfg, cnt_eff);
              sub_r       <= '0;
              rnd_r       <= '0;
              state_r     <= ST_ROUND;
            end else begin
              out_byte_r  <= q_item.data ^ ks_byte;
            end
          end
        end
        ST_ROUND: begin
          w_r   <= w_nxt;
          sub_r <= sub_r + 3'd1;
          if (sub_r == 3'd7) begin
            rnd_r <= rnd_r + RND_W'(1);
            if (rnd_r == RND_W'(DOUBLE_ROUNDS - 1)) begin
              state_r <= ST_FINAL;
            end
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 16; i++) begin
            ks_r[i] <= w_r[i] + init_cur[i];
          end
          counter_r <= counter_r + 32'd1;
          state_r   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_byte_r  <= hold_data_r ^ ks_r[0][7:0];
            state_r     <= ST_READY;
          end
        end
        default: state_r <= ST_READY;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_byte_r;

endmodule

[sv/chacha20_stream_cipher_unit.sv]
// ChaCha20 (IETF layout) byte-stream cipher: each input item is one byte, each
// output item is that byte XOR the matching keystream byte. Encrypt and decrypt
// are the same operation.
// Channels: in_valid/in_stall with in_data_byte and in_first (first byte of a
// message, restarts block counter at 0); out_valid/out_stall with out_cipher_byte.
// Key and nonce are 64-bit registers on the APB-style port at 8*index; write
// them only while the block is idle. They are used at the next block build.
// Input items go into a 4-entry queue; a back end consumes them one per cycle
// unless it is building a block or the output is stalled. A byte at block
// position 0 (or marked first) builds a new keystream block: each double round
// runs its column half, then its diagonal half, in the shared four-lane
// quarter-round unit, followed by the feed-forward add and the output register.
// The other 63 bytes of the block pass through the queue and the output register
// and come out at one per cycle while the output is not stalled. in_stall
// rises when the queue is full. A stalled output holds its byte; the back end
// may still start a block build but waits to emit; the queue keeps taking items
// until it fills. Reset (synchronous, active low) clears registers, counter and
// position, so the stream starts at block 0, byte 0.
module chacha20_stream_cipher_unit #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_first,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_cipher_byte,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cc20_pkg::ADDR_W-1:0] paddr,
  input  logic [cc20_pkg::DATA_W-1:0] pwdata,
  output logic [cc20_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  cc20_pkg::cc20_cfg_t  cfg;
  cc20_pkg::cc20_item_t q_item;
  logic                 q_valid;
  logic                 q_pop;

  cc20_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cc20_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_first     (in_first),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  cc20_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_byte (out_cipher_byte)
  );

endmodule

[bench/chacha20_stream_cipher_unit_test.sv]
module chacha20_stream_cipher_unit_test;

  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 66;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO} fill_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       typed;
    logic [7:0] want;
  } stim_row_t;

  // Reset key and nonce are zero, so the leading bytes of block 0 are the
  // well-known all-zero keystream: 76 b8 e0 ad a0 f1 ...
  localparam stim_row_t DIRECTED_ROWS [22] = '{
    '{8'h00, 1'b0, 1'b1, 8'h76},  // no first after reset: starts at block 0
    '{8'hff, 1'b0, 1'b1, 8'h47},
    '{8'h00, 1'b0, 1'b1, 8'he0},
    '{8'h00, 1'b0, 1'b1, 8'had},
    '{8'hff, 1'b0, 1'b1, 8'h5f},
    '{8'h00, 1'b0, 1'b1, 8'hf1},
    '{8'h5a, 1'b0, 1'b0, 8'h00},
    '{8'ha5, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b1, 8'h76},  // restart mid block
    '{8'hff, 1'b0, 1'b1, 8'h47},
    '{8'h80, 1'b1, 1'b1, 8'hf6},  // back-to-back first bytes
    '{8'h01, 1'b1, 1'b1, 8'h77},
    '{8'h00, 1'b0, 1'b1, 8'hb8},
    '{8'hff, 1'b0, 1'b1, 8'h1f},
    '{8'h00, 1'b0, 1'b1, 8'had},
    '{8'h7f, 1'b0, 1'b0, 8'h00},
    '{8'hfe, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'haa, 1'b0, 1'b0, 8'h00},
    '{8'hff, 1'b1, 1'b1, 8'h89},
    '{8'h3c, 1'b0, 1'b0, 8'h00},
    '{8'hc3, 1'b0, 1'b0, 8'h00}
  };

  localparam fill_kind_t PHASE_FILL [PHASES] = '{
    FILL_ONES, FILL_RANDOM, FILL_ZERO, FILL_RANDOM,
    FILL_RANDOM, FILL_ONES, FILL_RANDOM, FILL_ZERO
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_data_byte = '0;
  logic                          in_first = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_cipher_byte;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cc20_pkg::ADDR_W-1:0]   paddr = '0;
  logic [cc20_pkg::DATA_W-1:0]   pwdata = '0;
  logic [cc20_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  chacha20_stream_cipher_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cipher_byte (out_cipher_byte),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [63:0]            key_nonce_regs [6];
  cc20_pkg::cc20_block_t  keystream;
  logic [5:0]             byte_pos;
  logic [31:0]            block_ctr;

  logic [7:0]   expected_bytes [$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [31:0] spin_left(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic cc20_pkg::cc20_block_t quarter_mix(input cc20_pkg::cc20_block_t w,
                                                        input int a, input int b,
                                                        input int c, input int d);
    w[a] = w[a] + w[b]; w[d] = spin_left(w[d] ^ w[a], cc20_pkg::ROT_A);
    w[c] = w[c] + w[d]; w[b] = spin_left(w[b] ^ w[c], cc20_pkg::ROT_B);
    w[a] = w[a] + w[b]; w[d] = spin_left(w[d] ^ w[a], cc20_pkg::ROT_C);
    w[c] = w[c] + w[d]; w[b] = spin_left(w[b] ^ w[c], cc20_pkg::ROT_D);
    return w;
  endfunction

  function automatic cc20_pkg::cc20_block_t keystream_block(input logic [31:0] ctr);
    cc20_pkg::cc20_block_t start;
    cc20_pkg::cc20_block_t w;
    start[0] = cc20_pkg::SIGMA0;
    start[1] = cc20_pkg::SIGMA1;
    start[2] = cc20_pkg::SIGMA2;
    start[3] = cc20_pkg::SIGMA3;
    for (int k = 0; k < 4; k++) begin
      start[4 + 2 * k] = key_nonce_regs[k][31:0];
      start[5 + 2 * k] = key_nonce_regs[k][63:32];
    end
    start[12] = ctr;
    start[13] = key_nonce_regs[cc20_pkg::REG_NONCE_0_7][31:0];
    start[14] = key_nonce_regs[cc20_pkg::REG_NONCE_0_7][63:32];
    start[15] = key_nonce_regs[cc20_pkg::REG_NONCE_8_11][31:0];
    w = start;
    for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS_DEF; r++) begin
      w = quarter_mix(w, 0, 4, 8, 12);
      w = quarter_mix(w, 1, 5, 9, 13);
      w = quarter_mix(w, 2, 6, 10, 14);
      w = quarter_mix(w, 3, 7, 11, 15);
      w = quarter_mix(w, 0, 5, 10, 15);
      w = quarter_mix(w, 1, 6, 11, 12);
      w = quarter_mix(w, 2, 7, 8, 13);
      w = quarter_mix(w, 3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) w[k] = w[k] + start[k];
    return w;
  endfunction

  function automatic logic [7:0] predict_cipher(input logic [7:0] d, input logic f);
    logic [31:0] word;
    logic [7:0]  ks;
    if (f) begin
      block_ctr = '0;
      byte_pos = '0;
    end
    if (byte_pos == 0) begin
      keystream = keystream_block(block_ctr);
      block_ctr = block_ctr + 32'd1;
    end
    word = keystream[byte_pos[5:2]];
    ks = word[8 * byte_pos[1:0] +: 8];
    byte_pos = byte_pos + 6'd1;
    return d ^ ks;
  endfunction

  // typed rows carry a fixed expectation; the predictor still advances
  task automatic push_byte(input logic [7:0] d, input logic f,
                           input logic typed, input logic [7:0] want);
    logic [7:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_first <= f;
    predicted = predict_cipher(d, f);
    expected_bytes.push_back(typed ? want : predicted);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx <= cc20_pkg::REG_NONCE_0_7) key_nonce_regs[idx] = value;
    else if (idx == cc20_pkg::REG_NONCE_8_11) key_nonce_regs[idx] = {32'h0, value[31:0]};
  endtask

  task automatic read_back(input logic [2:0] idx);
    logic [63:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = key_nonce_regs[idx];
    // the short nonce register is only 32 bits wide
    if (idx == cc20_pkg::REG_NONCE_8_11 ? prdata[31:0] !== want[31:0] : prdata !== want)
      report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
  endtask

  task automatic configure(input fill_kind_t kind);
    logic [63:0] value;
    for (int i = cc20_pkg::REG_KEY_0_7; i <= cc20_pkg::REG_NONCE_8_11; i++) begin
      case (kind)
        FILL_ONES: value = '1;
        FILL_ZERO: value = '0;
        default:   value = {$urandom, $urandom};
      endcase
      write_reg(3'(i), value);
      read_back(3'(i));
    end
    // writes past the last register must be ignored
    write_reg(REG_SPARE_6, {$urandom, $urandom});
    write_reg(REG_SPARE_7, {$urandom, $urandom});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 76; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 76; end
      IDLE_BOTH:     begin send_idle_pct = 32; stall_pct = 32; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // messages of random length; a few continue without a first byte
  task automatic random_phase(input int count);
    int sent;
    int len;
    logic mark;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 150);
      mark = ($urandom_range(9) != 0);
      for (int k = 0; k < len && sent < count; k++) begin
        push_byte(8'($urandom_range(255)), mark && k == 0, 1'b0, 8'h00);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_output
    logic [7:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected cipher byte %h", out_cipher_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_cipher_byte !== want)
          report_mismatch($sformatf("cipher byte %h, expected %h", out_cipher_byte, want));
      end
    end
  end

  initial begin
    for (int i = 0; i < 6; i++) key_nonce_regs[i] = '0;
    keystream = '0;
    byte_pos = '0;
    block_ctr = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      push_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].first,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    in_valid <= 1'b0;

    // streams left mid block carry over, so new keys also land inside a block
    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(PHASE_FILL[p]);
      set_idle_mode(idle_mode_t'(p % 4));
      random_phase(ITEMS_PER_PHASE);
      in_valid <= 1'b0;
    end

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
sv/cc20_pkg.sv
sv/cc20_regs.sv
sv/cc20_front.sv
sv/cc20_core.sv
sv/chacha20_stream_cipher_unit.sv
bench/chacha20_stream_cipher_unit_test.sv
